>>> design/i2c_seq_pkg.sv
// Shared types, command codes and micro-step table of the I2C bit sequencer.
package i2c_seq_pkg;

   typedef logic [2:0]  func_type;
   typedef logic [3:0]  op_type;
   typedef logic [2:0]  step_type;
   typedef logic [15:0] delay_type;

   localparam func_type CMD_NONE    = 3'd0;
   localparam func_type CMD_START   = 3'd1;
   localparam func_type CMD_STOP    = 3'd2;
   localparam func_type CMD_WRITE   = 3'd3;
   localparam func_type CMD_READ    = 3'd4;
   localparam func_type CMD_PUT_ACK = 3'd5;
   localparam func_type CMD_GET_ACK = 3'd6;

   localparam op_type OP_SCL0   = 4'd0;
   localparam op_type OP_SCL1   = 4'd1;
   localparam op_type OP_SDA0   = 4'd2;
   localparam op_type OP_SDA1   = 4'd3;
   localparam op_type OP_SDAB   = 4'd4;
   localparam op_type OP_WAIT   = 4'd5;
   localparam op_type OP_SCLTX  = 4'd6;
   localparam op_type OP_SCLRX  = 4'd7;
   localparam op_type OP_SCLACK = 4'd8;

   localparam delay_type UNIT_DELAY_RESET = 16'd50;

   // Micro-step of a command at a step position.
   function automatic op_type seq_op(input func_type cmd, input step_type step);
      op_type op;
      op = OP_SCL0;
      case (cmd)
         CMD_START: begin
            case (step)
               3'd1:    op = OP_SDA1;
               3'd2:    op = OP_SCL1;
               3'd3:    op = OP_WAIT;
               3'd4:    op = OP_SDA0;
               3'd5:    op = OP_WAIT;
               default: op = OP_SCL0;
            endcase
         end
         CMD_STOP: begin
            case (step)
               3'd0:    op = OP_SCL0;
               3'd1:    op = OP_SDA0;
               3'd2:    op = OP_SCL1;
               3'd4:    op = OP_SDA1;
               default: op = OP_WAIT;
            endcase
         end
         CMD_WRITE: begin
            case (step)
               3'd1:    op = OP_SDAB;
               3'd2:    op = OP_WAIT;
               3'd3:    op = OP_WAIT;
               3'd4:    op = OP_SCLTX;
               3'd5:    op = OP_WAIT;
               default: op = OP_SCL0;
            endcase
         end
         CMD_READ: begin
            case (step)
               3'd1:    op = OP_SDA1;
               3'd3:    op = OP_WAIT;
               3'd4:    op = OP_WAIT;
               3'd5:    op = OP_SCLRX;
               3'd6:    op = OP_WAIT;
               default: op = OP_SCL0;
            endcase
         end
         CMD_PUT_ACK: begin
            case (step)
               3'd1:    op = OP_SDAB;
               3'd2:    op = OP_WAIT;
               3'd3:    op = OP_WAIT;
               3'd4:    op = OP_SCL1;
               3'd5:    op = OP_WAIT;
               default: op = OP_SCL0;
            endcase
         end
         CMD_GET_ACK: begin
            case (step)
               3'd1:    op = OP_SDA1;
               3'd2:    op = OP_WAIT;
               3'd3:    op = OP_WAIT;
               3'd4:    op = OP_SCLACK;
               3'd5:    op = OP_WAIT;
               default: op = OP_SCL0;
            endcase
         end
         default: op = OP_SCL0;
      endcase
      return op;
   endfunction

endpackage

>>> design/i2c_seq_if.sv
// Request and response channel interfaces of the I2C bit sequencer.
interface i2c_seq_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] data_byte;
   logic       ack_level;
   logic       sda_sample;

   modport source (output valid, func, data_byte, ack_level, sda_sample, input ready);
   modport sink   (input valid, func, data_byte, ack_level, sda_sample, output ready);
endinterface

interface i2c_seq_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;
   logic       ack_seen;

   modport source (output valid, scl_level, sda_drive, busy_res, done_res, read_byte,
                   ack_seen, input ready);
   modport sink   (input valid, scl_level, sda_drive, busy_res, done_res, read_byte,
                   ack_seen, output ready);
endinterface

>>> design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one tick item in, one pin/status item out.
// Response valid is registered and rises in the cycle after request accept.
// Throughput: 1 item per cycle; request ready stays high while the response
//   register is empty or being drained in the same cycle.
// Reset (synchronous, active high): sequencer idle, SCL/SDA released high,
//   unit delay back to 50 ticks, read byte and ack status cleared.
module i2c_master_bit_sequencer
   import i2c_seq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [15:0]    csr_wdata,
   i2c_seq_req_if.sink    req_chan,
   i2c_seq_rsp_if.source  rsp_chan
);

   // Architectural state of the sequencer
   delay_type delay_ff;
   func_type  cmd_ff,   cmd_in;
   step_type  step_ff,  step_in;
   logic [2:0] bit_ff,  bit_in;
   delay_type wait_ff,  wait_in;
   logic [7:0] shift_ff, shift_in;
   logic      scl_ff,   scl_in;
   logic      sda_ff,   sda_in;
   logic      ack_ff,   ack_in;
   logic [7:0] rd_ff,   rd_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_busy_ff,  rsp_done_ff;
   logic       busy_in,      done_in;

   logic       req_fire;

   // Take a new tick whenever the response slot is free or drains now.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_valid_in   = req_fire || (rsp_valid_ff && !rsp_chan.ready);

   // One tick of the sequencer: command pickup, then one micro-step.
   always_comb begin
      func_type  cmd_eff;
      op_type    op;
      logic      step_done;
      logic [16:0] wait_sum;
      delay_type limit;
      logic      loops;
      step_type  loop_first, loop_last;
      logic [3:0] step_sum, seq_len;

      cmd_in   = cmd_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      wait_in  = wait_ff;
      shift_in = shift_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      rd_in    = rd_ff;
      busy_in  = 1'b0;
      done_in  = 1'b0;

      // Pick up a command only from idle; anything else is dropped.
      cmd_eff = cmd_ff;
      if (cmd_ff == CMD_NONE && req_chan.func inside {[CMD_START:CMD_GET_ACK]}) begin
         cmd_eff = req_chan.func;
         step_in = '0;
         bit_in  = '0;
         wait_in = '0;
         if (req_chan.func == CMD_WRITE) begin
            shift_in = req_chan.data_byte;
         end else if (req_chan.func == CMD_PUT_ACK) begin
            // put ack reuses the SDA-from-MSB step
            shift_in = {req_chan.ack_level, 7'd0};
         end
      end
      cmd_in = cmd_eff;

      op        = seq_op(cmd_eff, step_in);
      step_done = 1'b1;
      wait_sum  = {1'b0, wait_in} + 17'd1;
      limit     = (delay_ff == '0) ? 16'd1 : delay_ff;

      loops      = (cmd_eff == CMD_WRITE) || (cmd_eff == CMD_READ);
      loop_first = (cmd_eff == CMD_READ) ? 3'd2 : 3'd0;
      loop_last  = (cmd_eff == CMD_READ) ? 3'd6 : 3'd5;
      seq_len    = (cmd_eff == CMD_READ) ? 4'd8 : 4'd7;
      step_sum   = {1'b0, step_in} + 4'd1;

      if (cmd_eff != CMD_NONE) begin
         busy_in = 1'b1;
         case (op)
            OP_SCL0:   scl_in = 1'b0;
            OP_SCL1:   scl_in = 1'b1;
            OP_SDA0:   sda_in = 1'b0;
            OP_SDA1:   sda_in = 1'b1;
            OP_SDAB:   sda_in = shift_in[7];
            OP_SCLTX: begin
               scl_in   = 1'b1;
               shift_in = {shift_in[6:0], 1'b0};
            end
            OP_SCLRX: begin
               scl_in   = 1'b1;
               shift_in = {shift_in[6:0], req_chan.sda_sample};
            end
            OP_SCLACK: begin
               scl_in = 1'b1;
               ack_in = req_chan.sda_sample;
            end
            default: begin
               // wait: hold pins for limit ticks
               if (wait_sum >= {1'b0, limit}) begin
                  wait_in = '0;
               end else begin
                  wait_in   = wait_sum[15:0];
                  step_done = 1'b0;
               end
            end
         endcase

         if (step_done) begin
            if (loops && step_in == loop_last && bit_in != 3'd7) begin
               bit_in  = bit_in + 3'd1;
               step_in = loop_first;
            end else if (step_sum >= seq_len) begin
               if (cmd_eff == CMD_READ) begin
                  rd_in = shift_in;
               end
               done_in = 1'b1;
               cmd_in  = CMD_NONE;
               step_in = '0;
               bit_in  = '0;
            end else begin
               step_in = step_sum[2:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= UNIT_DELAY_RESET;
         cmd_ff       <= CMD_NONE;
         step_ff      <= '0;
         bit_ff       <= '0;
         wait_ff      <= '0;
         shift_ff     <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            delay_ff <= csr_wdata;
         end
         if (req_fire) begin
            cmd_ff   <= cmd_in;
            step_ff  <= step_in;
            bit_ff   <= bit_in;
            wait_ff  <= wait_in;
            shift_ff <= shift_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            rd_ff    <= rd_in;
         end
      end
   end

   // Per-item status flags ride with the response; pins come from state.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_busy_ff <= busy_in;
         rsp_done_ff <= done_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_level = scl_ff;
   assign rsp_chan.sda_drive = sda_ff;
   assign rsp_chan.busy_res  = rsp_busy_ff;
   assign rsp_chan.done_res  = rsp_done_ff;
   assign rsp_chan.read_byte = rd_ff;
   assign rsp_chan.ack_seen  = ack_ff;

endmodule

>>> design/i2c_seq_checker.sv
// Port-level assertions for the I2C bit sequencer, bound to the top level.
module i2c_seq_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       scl_level,
   input logic       sda_drive,
   input logic       busy_res,
   input logic       done_res,
   input logic [7:0] read_byte,
   input logic       ack_seen
);

   // done only on a tick that ran a step
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!done_res || busy_res))
      else $error("done_res without busy_res");

   // every accepted tick yields a response next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted item produced no response");

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(scl_level)
         && $stable(sda_drive) && $stable(busy_res) && $stable(done_res)
         && $stable(read_byte) && $stable(ack_seen)))
      else $error("stalled response changed");

   // response slot empties out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind i2c_master_bit_sequencer i2c_seq_checker u_i2c_seq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .scl_level (rsp_chan.scl_level),
   .sda_drive (rsp_chan.sda_drive),
   .busy_res  (rsp_chan.busy_res),
   .done_res  (rsp_chan.done_res),
   .read_byte (rsp_chan.read_byte),
   .ack_seen  (rsp_chan.ack_seen)
);

>>> test/i2c_seq_checker.sv
// Scoreboard for the I2C bit sequencer: pin-level predictor and response compare.
module i2c_seq_scoreboard
   import i2c_seq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   i2c_seq_req_if      req_mon,
   i2c_seq_rsp_if      rsp_mon,
   output int          fail_count,
   output int          pending,
   output logic        cmd_idle
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rd;
      logic       ack;
   } pin_state_type;

   // rows: start, stop, write, read, put ack, get ack
   localparam op_type STEP_TABLE [6][8] = '{
      '{OP_SCL0, OP_SDA1, OP_SCL1, OP_WAIT, OP_SDA0,   OP_WAIT,  OP_SCL0, OP_SCL0},
      '{OP_SCL0, OP_SDA0, OP_SCL1, OP_WAIT, OP_SDA1,   OP_WAIT,  OP_WAIT, OP_WAIT},
      '{OP_SCL0, OP_SDAB, OP_WAIT, OP_WAIT, OP_SCLTX,  OP_WAIT,  OP_SCL0, OP_SCL0},
      '{OP_SCL0, OP_SDA1, OP_SCL0, OP_WAIT, OP_WAIT,   OP_SCLRX, OP_WAIT, OP_SCL0},
      '{OP_SCL0, OP_SDAB, OP_WAIT, OP_WAIT, OP_SCL1,   OP_WAIT,  OP_SCL0, OP_SCL0},
      '{OP_SCL0, OP_SDA1, OP_WAIT, OP_WAIT, OP_SCLACK, OP_WAIT,  OP_SCL0, OP_SCL0}
   };

   delay_type  unit_delay;
   func_type   cur_cmd;
   logic [3:0] step_idx;
   logic [3:0] bit_idx;
   logic [15:0] wait_cnt;
   logic [7:0] shift_reg;
   logic [7:0] rd_reg;
   logic       scl_q;
   logic       sda_q;
   logic       ack_q;

   pin_state_type pin_states_q[$];
   pin_state_type want;
   int            errors;

   // One sequencer tick: returns the pin/status item it produces.
   function automatic pin_state_type advance_tick(input func_type f, input logic [7:0] d,
                                                  input logic a, input logic s);
      pin_state_type r;
      op_type        op;
      logic          step_done;
      logic [15:0]   lim;
      int            row;
      r = '0;
      if (cur_cmd == CMD_NONE && f >= CMD_START && f <= CMD_GET_ACK) begin
         cur_cmd  = f;
         step_idx = '0;
         bit_idx  = '0;
         wait_cnt = '0;
         if (f == CMD_WRITE)
            shift_reg = d;
         else if (f == CMD_PUT_ACK)
            shift_reg = a ? 8'h80 : 8'h00;
      end
      if (cur_cmd != CMD_NONE) begin
         row       = int'(cur_cmd) - 1;
         op        = STEP_TABLE[row][step_idx[2:0]];
         r.busy    = 1'b1;
         step_done = 1'b1;
         case (op)
            OP_SCL0: scl_q = 1'b0;
            OP_SCL1: scl_q = 1'b1;
            OP_SDA0: sda_q = 1'b0;
            OP_SDA1: sda_q = 1'b1;
            OP_SDAB: sda_q = shift_reg[7];
            OP_SCLTX: begin
               scl_q     = 1'b1;
               shift_reg = {shift_reg[6:0], 1'b0};
            end
            OP_SCLRX: begin
               scl_q     = 1'b1;
               shift_reg = {shift_reg[6:0], s};
            end
            OP_SCLACK: begin
               scl_q = 1'b1;
               ack_q = s;
            end
            default: begin
               // a zero delay still costs one tick
               lim      = (unit_delay == '0) ? 16'd1 : unit_delay;
               wait_cnt = wait_cnt + 16'd1;
               if (wait_cnt >= lim)
                  wait_cnt = '0;
               else
                  step_done = 1'b0;
            end
         endcase
         if (step_done) begin
            if (((cur_cmd == CMD_WRITE && step_idx == 4'd5) ||
                 (cur_cmd == CMD_READ && step_idx == 4'd6)) && bit_idx < 4'd7) begin
               bit_idx  = bit_idx + 4'd1;
               step_idx = (cur_cmd == CMD_READ) ? 4'd2 : 4'd0;
            end else begin
               step_idx = step_idx + 4'd1;
               if (step_idx >= ((cur_cmd == CMD_READ) ? 4'd8 : 4'd7)) begin
                  if (cur_cmd == CMD_READ)
                     rd_reg = shift_reg;
                  r.done   = 1'b1;
                  cur_cmd  = CMD_NONE;
                  step_idx = '0;
                  bit_idx  = '0;
               end
            end
         end
      end
      r.scl = scl_q;
      r.sda = sda_q;
      r.rd  = rd_reg;
      r.ack = ack_q;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         unit_delay = UNIT_DELAY_RESET;
         cur_cmd    = CMD_NONE;
         step_idx   = '0;
         bit_idx    = '0;
         wait_cnt   = '0;
         shift_reg  = '0;
         rd_reg     = '0;
         scl_q      = 1'b1;
         sda_q      = 1'b1;
         ack_q      = 1'b0;
         errors     = 0;
         pin_states_q.delete();
      end else begin
         if (csr_we)
            unit_delay = csr_wdata;
         // drain before fill: a response at this edge belongs to an older item
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pin_states_q.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual scl=%0b sda=%0b busy=%0b",
                        $time, rsp_mon.scl_level, rsp_mon.sda_drive, rsp_mon.busy_res);
               errors++;
            end else begin
               want = pin_states_q.pop_front();
               check_field("scl_level", want.scl, rsp_mon.scl_level);
               check_field("sda_drive", want.sda, rsp_mon.sda_drive);
               check_field("busy_res", want.busy, rsp_mon.busy_res);
               check_field("done_res", want.done, rsp_mon.done_res);
               check_field("read_byte", want.rd, rsp_mon.read_byte);
               check_field("ack_seen", want.ack, rsp_mon.ack_seen);
            end
         end
         if (req_mon.valid && req_mon.ready)
            pin_states_q.push_back(advance_tick(req_mon.func, req_mon.data_byte,
                                                req_mon.ack_level, req_mon.sda_sample));
      end
      pending    <= pin_states_q.size();
      cmd_idle   <= (cur_cmd == CMD_NONE);
      fail_count <= errors;
   end

endmodule

>>> test/i2c_master_bit_sequencer_tb.sv
// Top-level bench for the I2C bit sequencer: tick stimulus, back-pressure and verdict.
module i2c_master_bit_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import i2c_seq_pkg::*;

   localparam int       CYCLE_LIMIT = 100_000;    // watchdog bound for a full run
   localparam int       HOLD_CYCLES = 300;        // long receiver stall
   localparam func_type CMD_UNUSED  = 3'd7;       // undefined code, must be ignored

   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   int fail_count;
   int pending;
   logic cmd_idle;

   // idle percentages of each side, changed per phase
   int send_idle_pct;
   int recv_idle_pct;

   // receiver hold-off requests; the receiver process counts the stall itself
   int hold_asked;
   int hold_served;
   int hold_left;
   int cycle_count;

   i2c_seq_req_if req_if ();
   i2c_seq_rsp_if rsp_if ();

   i2c_master_bit_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   i2c_seq_scoreboard u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending),
      .cmd_idle   (cmd_idle)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hang or a lost response ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("i2c_master_bit_sequencer_tb: FAIL");
      $finish;
   end

   // Response side: random ready, plus an occasional long stall on request.
   initial begin
      rsp_if.ready = 1'b0;
      hold_served  = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic sda_for(input sda_mode_type m);
      case (m)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom_range(1, 0));
      endcase
   endfunction

   // Offer one tick item, with random idle cycles ahead of it; returns on accept.
   // valid stays high after accept so back-to-back items need no re-raise.
   task automatic send_tick(input func_type f, input logic [7:0] d, input logic a,
                            input logic s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= f;
      req_if.data_byte  <= d;
      req_if.ack_level  <= a;
      req_if.sda_sample <= s;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   // Stop offering and wait until every predicted item has come back.
   // pending is registered, which is safe once valid is low.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending != 0);
   endtask

   // Run one command to completion. The noisy form throws random codes at the
   // block while it is busy; those must be ignored (or start the next command
   // once it is idle again, which the predictor follows as well).
   task automatic issue_cmd(input func_type f, input logic [7:0] d, input logic a,
                            input sda_mode_type mode, input bit noisy);
      int       k;
      func_type filler;
      k = 0;
      send_tick(f, d, a, sda_for(mode));
      // cmd_idle lags one item, so at least one more tick goes out before it counts
      do begin
         filler = (noisy && k < 10) ? func_type'($urandom_range(7, 1)) : CMD_NONE;
         send_tick(filler, 8'($urandom), 1'($urandom), sda_for(mode));
         k++;
      end while (!cmd_idle);
   endtask

   // Bring the sequencer to idle, drain the pipe, then change the unit delay.
   task automatic settle_and_config(input logic [15:0] value);
      do
         send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      while (!cmd_idle);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Free-running ticks: mostly real commands so the block stays busy and
   // commands land right after done; some undefined codes and plain idle.
   task automatic random_run(input int n);
      int       r;
      func_type f;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 70)
            f = func_type'($urandom_range(CMD_GET_ACK, CMD_START));
         else if (r < 80)
            f = CMD_UNUSED;
         else
            f = CMD_NONE;
         send_tick(f, 8'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.func          = CMD_NONE;
      req_if.data_byte     = '0;
      req_if.ack_level     = 1'b0;
      req_if.sda_sample    = 1'b0;
      hold_asked           = 0;
      send_idle_pct        = 35;
      recv_idle_pct        = 60;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset value of the unit delay (50 ticks) seen through a start condition.
      issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);

      // Directed pass at the shortest delay.
      settle_and_config(16'd1);
      issue_cmd(CMD_WRITE, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      issue_cmd(CMD_WRITE, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
      issue_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);  // busy-ignore
      issue_cmd(CMD_WRITE, 8'h5A, 1'b1, SDA_RANDOM, 1'b0);
      issue_cmd(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);     // reads 0xFF
      issue_cmd(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0);      // reads 0x00
      issue_cmd(CMD_READ, 8'h3C, 1'b0, SDA_RANDOM, 1'b1);
      issue_cmd(CMD_PUT_ACK, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      issue_cmd(CMD_PUT_ACK, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
      issue_cmd(CMD_GET_ACK, 8'h00, 1'b0, SDA_LOW, 1'b0);   // ack
      issue_cmd(CMD_GET_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0);  // nack
      issue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      // undefined code while idle acts like no command
      send_tick(CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
      send_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
      issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);

      // Zero delay must behave as a one-tick wait.
      settle_and_config(16'd0);
      issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      issue_cmd(CMD_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0);

      // Phase A: sender idles 35%, receiver 60%; one long receiver stall
      // fills the response register and stalls the request side.
      settle_and_config(16'd2);
      random_run(150);
      hold_asked++;
      random_run(150);

      // Phase B: roles swapped; one pause until everything has come back.
      send_idle_pct = 60;
      recv_idle_pct = 35;
      settle_and_config(16'd1);
      random_run(150);
      wait_drained();
      random_run(75);
      settle_and_config(16'd3);
      random_run(100);

      // Phase C: no idling on either side, then a longer delay.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle_and_config(16'd0);
      random_run(100);
      settle_and_config(16'd100);
      issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      settle_and_config(16'd1);
      random_run(100);

      wait_drained();
      repeat (5) @(posedge clock);
      if (fail_count == 0)
         $display("i2c_master_bit_sequencer_tb: PASS");
      else
         $display("i2c_master_bit_sequencer_tb: FAIL");
      $finish;
   end

endmodule
